// ===== hw/rtl/mrf_pkg.sv =====
package mrf_pkg;

  localparam int unsigned MAP_ENTRIES  = 256;
  localparam int unsigned IDX_W        = $clog2(MAP_ENTRIES);
  localparam int unsigned CNT_W        = $clog2(MAP_ENTRIES + 1);
  localparam int unsigned RUN_SLOTS    = (MAP_ENTRIES + 1) / 2;
  localparam int unsigned SLOT_W       = $clog2(RUN_SLOTS);
  localparam int unsigned TOTAL_W      = $clog2(RUN_SLOTS + 1);
  localparam int unsigned MAX_REPORTED = 64;
  localparam int unsigned WANT_W       = 7;

  // presence map port request
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic             wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } map_req_t;

  // run table port request
  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] waddr;
    logic [IDX_W-1:0]  wstart;
    logic [CNT_W-1:0]  wlen;
    logic              re;
    logic [SLOT_W-1:0] raddr;
  } run_req_t;

endpackage

// ===== hw/rtl/mrf_if.sv =====
interface mrf_req_if import mrf_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                mode;
  logic [IDX_W-1:0]    entry_index;
  logic                entry_value;
  logic [WANT_W-1:0]   range_count;

  modport source (output valid, mode, entry_index, entry_value, range_count, input ready);
  modport sink   (input valid, mode, entry_index, entry_value, range_count, output ready);
endinterface

interface mrf_res_if import mrf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] run_start;
  logic [CNT_W-1:0] run_end;
  logic [CNT_W-1:0] run_length;
  logic [CNT_W-1:0] present_count;
  logic             no_gaps;
  logic             last_result;

  modport source (output valid, run_start, run_end, run_length, present_count, no_gaps,
                  last_result, input ready);
  modport sink   (input valid, run_start, run_end, run_length, present_count, no_gaps,
                  last_result, output ready);
endinterface

// ===== hw/rtl/mrf_map_ram.sv =====
module mrf_map_ram import mrf_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  map_req_t req_i,
  output logic     rdata_o
);

  logic                   mem_q [MAP_ENTRIES];
  logic [MAP_ENTRIES-1:0] vld_q;
  logic                   rdata_q;

  // unwritten entries read as missing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (req_i.we) begin
      vld_q[req_i.waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr] & vld_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/mrf_run_ram.sv =====
module mrf_run_ram import mrf_pkg::*; (
  input  logic             clk_i,
  input  run_req_t         req_i,
  output logic [IDX_W-1:0] rstart_o,
  output logic [CNT_W-1:0] rlen_o
);

  logic [IDX_W-1:0] start_mem_q [RUN_SLOTS];
  logic [CNT_W-1:0] len_mem_q   [RUN_SLOTS];
  logic [IDX_W-1:0] rstart_q;
  logic [CNT_W-1:0] rlen_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      start_mem_q[req_i.waddr] <= req_i.wstart;
      len_mem_q[req_i.waddr]   <= req_i.wlen;
    end
    if (req_i.re) begin
      rstart_q <= start_mem_q[req_i.raddr];
      rlen_q   <= len_mem_q[req_i.raddr];
    end
  end

  assign rstart_o = rstart_q;
  assign rlen_o   = rlen_q;

endmodule

// ===== hw/rtl/missing_run_finder.sv =====
// Missing run finder: presence bitmap with a length-sorted report of gaps.
// Request channel (req_i): mode 0 writes one map entry (entry_index,
// entry_value) and gives no result; mode 1 is a query that reports up to
// range_count (0 read as 1, at most 64) missing runs, longest first, ties in start order.
// Result channel (res_o): one result per reported run, or a single no_gaps
// result; last_result marks the end of a query.
// cfg_we_i/cfg_wdata_i set entries_in_use (n); write only while idle.
// A query scans the entries in use (check, read, evaluate per entry over the
// single map read port); each run found goes into the run table by insertion
// sort through one read and one write port, shifting shorter runs down one
// slot; each reported run is then read and loaded into the output register.
// A new request is taken only once the previous query has loaded its last result.
// Reset: map reads as all missing, n = 256, no results pending.
// A stalled receiver holds the output register; the sequencer waits for it
// and loses nothing.
module missing_run_finder import mrf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CNT_W-1:0] cfg_wdata_i,
  mrf_req_if.sink          req_i,
  mrf_res_if.source        res_o
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_SCAN_CHK = 4'd1;
  localparam logic [3:0] S_SCAN_RD = 4'd2;
  localparam logic [3:0] S_SCAN_EV = 4'd3;
  localparam logic [3:0] S_INS_RD  = 4'd4;
  localparam logic [3:0] S_INS_CMP = 4'd5;
  localparam logic [3:0] S_NOGAP   = 4'd6;
  localparam logic [3:0] S_REP_RD  = 4'd7;
  localparam logic [3:0] S_REP_LD  = 4'd8;

  localparam logic [CNT_W-1:0]  MapEntries = CNT_W'(MAP_ENTRIES);
  localparam logic [WANT_W-1:0] MaxRep     = WANT_W'(MAX_REPORTED);

  logic [3:0]         state_q, state_d;
  logic [CNT_W-1:0]   cfg_q;
  logic [CNT_W-1:0]   i_q, i_d;
  logic [IDX_W-1:0]   cur_q, cur_d;
  logic               in_run_q, in_run_d;
  logic [CNT_W-1:0]   present_q, present_d;
  logic [TOTAL_W-1:0] total_q, total_d;
  logic [TOTAL_W-1:0] pos_q, pos_d;
  logic [IDX_W-1:0]   ins_start_q, ins_start_d;
  logic [CNT_W-1:0]   ins_len_q, ins_len_d;
  logic [WANT_W-1:0]  want_q, want_d;
  logic [WANT_W-1:0]  k_q, k_d;

  logic               ovld_q, ovld_d;
  logic [IDX_W-1:0]   o_start_q, o_start_d;
  logic [CNT_W-1:0]   o_end_q, o_end_d;
  logic [CNT_W-1:0]   o_len_q, o_len_d;
  logic [CNT_W-1:0]   o_pres_q, o_pres_d;
  logic               o_nogap_q, o_nogap_d;
  logic               o_last_q, o_last_d;

  map_req_t           map_req;
  run_req_t           run_req;
  logic               map_bit;
  logic [IDX_W-1:0]   r_start;
  logic [CNT_W-1:0]   r_len;
  logic [CNT_W-1:0]   n_use;
  logic               out_free;
  logic [WANT_W-1:0]  want_clamp;
  logic [TOTAL_W-1:0] pos_m1;
  logic               k_last;

  mrf_map_ram u_map (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (map_req),
    .rdata_o(map_bit)
  );

  mrf_run_ram u_runs (
    .clk_i   (clk_i),
    .req_i   (run_req),
    .rstart_o(r_start),
    .rlen_o  (r_len)
  );

  // scan length saturates at map size
  assign n_use    = (cfg_q > MapEntries) ? MapEntries : cfg_q;
  assign out_free = !ovld_q || res_o.ready;
  assign pos_m1   = pos_q - TOTAL_W'(1);
  assign k_last   = (k_q + WANT_W'(1)) == want_q;

  always_comb begin
    want_clamp = want_q;
    if (want_q == '0) begin
      want_clamp = WANT_W'(1);
    end else if (want_q > MaxRep) begin
      want_clamp = MaxRep;
    end
    if (TOTAL_W'(want_clamp) > total_q) begin
      want_clamp = WANT_W'(total_q);
    end
  end

  assign req_i.ready = (state_q == S_IDLE);

  always_comb begin
    state_d     = state_q;
    i_d         = i_q;
    cur_d       = cur_q;
    in_run_d    = in_run_q;
    present_d   = present_q;
    total_d     = total_q;
    pos_d       = pos_q;
    ins_start_d = ins_start_q;
    ins_len_d   = ins_len_q;
    want_d      = want_q;
    k_d         = k_q;
    ovld_d      = ovld_q && !res_o.ready;
    o_start_d   = o_start_q;
    o_end_d     = o_end_q;
    o_len_d     = o_len_q;
    o_pres_d    = o_pres_q;
    o_nogap_d   = o_nogap_q;
    o_last_d    = o_last_q;

    map_req       = '0;
    map_req.waddr = req_i.entry_index;
    map_req.wdata = req_i.entry_value;
    map_req.raddr = i_q[IDX_W-1:0];
    run_req       = '0;

    case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          if (!req_i.mode) begin
            map_req.we = 1'b1;
          end else begin
            want_d    = req_i.range_count;
            i_d       = '0;
            in_run_d  = 1'b0;
            present_d = '0;
            total_d   = '0;
            state_d   = S_SCAN_CHK;
          end
        end
      end
      S_SCAN_CHK: begin
        if (i_q == n_use) begin
          if (in_run_q) begin
            // gap reaching the end of the area in use
            in_run_d    = 1'b0;
            ins_start_d = cur_q;
            ins_len_d   = n_use - {1'b0, cur_q};
            pos_d       = total_q;
            state_d     = S_INS_RD;
          end else if (total_q == '0) begin
            state_d = S_NOGAP;
          end else begin
            want_d  = want_clamp;
            k_d     = '0;
            state_d = S_REP_RD;
          end
        end else begin
          state_d = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        map_req.re = 1'b1;
        state_d    = S_SCAN_EV;
      end
      S_SCAN_EV: begin
        i_d     = i_q + CNT_W'(1);
        state_d = S_SCAN_CHK;
        if (map_bit) begin
          present_d = present_q + CNT_W'(1);
          if (in_run_q) begin
            in_run_d    = 1'b0;
            ins_start_d = cur_q;
            ins_len_d   = i_q - {1'b0, cur_q};
            pos_d       = total_q;
            state_d     = S_INS_RD;
          end
        end else if (!in_run_q) begin
          in_run_d = 1'b1;
          cur_d    = i_q[IDX_W-1:0];
        end
      end
      S_INS_RD: begin
        if (pos_q == '0) begin
          run_req.we     = 1'b1;
          run_req.waddr  = '0;
          run_req.wstart = ins_start_q;
          run_req.wlen   = ins_len_q;
          total_d        = total_q + TOTAL_W'(1);
          state_d        = S_SCAN_CHK;
        end else begin
          run_req.re    = 1'b1;
          run_req.raddr = pos_m1[SLOT_W-1:0];
          state_d       = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        run_req.we    = 1'b1;
        run_req.waddr = pos_q[SLOT_W-1:0];
        if (r_len < ins_len_q) begin
          // shorter run moves down one slot
          run_req.wstart = r_start;
          run_req.wlen   = r_len;
          pos_d          = pos_m1;
          state_d        = S_INS_RD;
        end else begin
          run_req.wstart = ins_start_q;
          run_req.wlen   = ins_len_q;
          total_d        = total_q + TOTAL_W'(1);
          state_d        = S_SCAN_CHK;
        end
      end
      S_NOGAP: begin
        if (out_free) begin
          ovld_d    = 1'b1;
          o_start_d = '0;
          o_end_d   = '0;
          o_len_d   = '0;
          o_pres_d  = present_q;
          o_nogap_d = 1'b1;
          o_last_d  = 1'b1;
          state_d   = S_IDLE;
        end
      end
      S_REP_RD: begin
        if (out_free) begin
          run_req.re    = 1'b1;
          run_req.raddr = SLOT_W'(k_q);
          state_d       = S_REP_LD;
        end
      end
      S_REP_LD: begin
        ovld_d    = 1'b1;
        o_start_d = r_start;
        o_end_d   = {1'b0, r_start} + r_len;
        o_len_d   = r_len;
        o_pres_d  = present_q;
        o_nogap_d = 1'b0;
        o_last_d  = k_last;
        k_d       = k_q + WANT_W'(1);
        state_d   = k_last ? S_IDLE : S_REP_RD;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cfg_q    <= MapEntries;
      i_q      <= '0;
      in_run_q <= 1'b0;
      total_q  <= '0;
      pos_q    <= '0;
      k_q      <= '0;
      want_q   <= '0;
      ovld_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      i_q      <= i_d;
      in_run_q <= in_run_d;
      total_q  <= total_d;
      pos_q    <= pos_d;
      k_q      <= k_d;
      want_q   <= want_d;
      ovld_q   <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q       <= cur_d;
    present_q   <= present_d;
    ins_start_q <= ins_start_d;
    ins_len_q   <= ins_len_d;
    o_start_q   <= o_start_d;
    o_end_q     <= o_end_d;
    o_len_q     <= o_len_d;
    o_pres_q    <= o_pres_d;
    o_nogap_q   <= o_nogap_d;
    o_last_q    <= o_last_d;
  end

  assign res_o.valid         = ovld_q;
  assign res_o.run_start     = o_start_q;
  assign res_o.run_end       = o_end_q;
  assign res_o.run_length    = o_len_q;
  assign res_o.present_count = o_pres_q;
  assign res_o.no_gaps       = o_nogap_q;
  assign res_o.last_result   = o_last_q;

  // run table never overflows
  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= TOTAL_W'(RUN_SLOTS))
    else $error("run count beyond table size");

  // insertion point stays within filled part of the table
  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INS_RD || state_q == S_INS_CMP) |-> pos_q <= total_q)
    else $error("insertion position beyond run count");

  // report index stays below the clamped request
  a_rep_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_REP_LD) |-> (k_q < want_q && TOTAL_W'(want_q) <= total_q))
    else $error("report index out of range");

  // a loaded result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_REP_LD) |-> !ovld_q)
    else $error("result register overwritten");

endmodule

// ===== verif/tb_missing_run_finder.sv =====
`timescale 1ns / 100ps

module tb_missing_run_finder import mrf_pkg::*; ();

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;
  localparam int unsigned CYCLE_LIMIT = 4000000;

  // expected result of one reported run
  typedef struct packed {
    logic [IDX_W-1:0] run_start;
    logic [CNT_W-1:0] run_end;
    logic [CNT_W-1:0] run_length;
    logic [CNT_W-1:0] present_count;
    logic             no_gaps;
    logic             last_result;
  } run_rec_t;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [CNT_W-1:0] cfg_wdata_i;

  mrf_req_if req_if ();
  mrf_res_if res_if ();

  missing_run_finder u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req_i      (req_if.sink),
    .res_o      (res_if.source)
  );

  // shadow of the block's state
  logic           map_shadow [MAP_ENTRIES];
  int unsigned    span_shadow;
  run_rec_t       expected_runs [$];
  bit             failed;
  bit             idle_on;
  int unsigned    cycle_cnt = 0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Scan the shadow map, sort the runs longest first (stable on ties) and
  // queue the results the block should report for this query.
  task automatic predict_runs(input int unsigned want);
    int unsigned starts [$];
    int unsigned lens [$];
    int unsigned present, cur, pos, k;
    bit in_gap;
    run_rec_t r;
    present = 0;
    in_gap = 0;
    cur = 0;
    for (int unsigned i = 0; i <= span_shadow; i++) begin
      if (i == span_shadow || map_shadow[i]) begin
        if (i < span_shadow) present++;
        if (in_gap) begin
          // insertion after every run of equal or greater length
          pos = 0;
          while (pos < lens.size() && lens[pos] >= i - cur) pos++;
          starts.insert(pos, cur);
          lens.insert(pos, i - cur);
          in_gap = 0;
        end
      end else if (!in_gap) begin
        in_gap = 1;
        cur = i;
      end
    end
    if (lens.size() == 0) begin
      r = '0;
      r.present_count = CNT_W'(present);
      r.no_gaps = 1'b1;
      r.last_result = 1'b1;
      expected_runs.push_back(r);
    end else begin
      if (want == 0) want = 1;
      if (want > MAX_REPORTED) want = MAX_REPORTED;
      if (want > lens.size()) want = lens.size();
      for (k = 0; k < want; k++) begin
        r.run_start = IDX_W'(starts[k]);
        r.run_end = CNT_W'(starts[k] + lens[k]);
        r.run_length = CNT_W'(lens[k]);
        r.present_count = CNT_W'(present);
        r.no_gaps = 1'b0;
        r.last_result = (k + 1 == want);
        expected_runs.push_back(r);
      end
    end
  endtask

  // Send one request, with a random hold-off first when idling is on.
  // valid stays high after acceptance so that requests can follow back to back.
  task automatic send_request(input logic mode, input int unsigned idx,
                              input logic val, input int unsigned want);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    req_if.valid       <= 1'b1;
    req_if.mode        <= mode;
    req_if.entry_index <= idx[IDX_W-1:0];
    req_if.entry_value <= val;
    req_if.range_count <= want[WANT_W-1:0];
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    if (mode == MODE_WRITE) map_shadow[idx] = val;
    else predict_runs(want);
  endtask

  // drop valid once no further request follows
  task automatic stop_requests;
    req_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_entry(input int unsigned idx, input logic val);
    send_request(MODE_WRITE, idx, val, $urandom_range(0, 127));
  endtask

  task automatic query_runs(input int unsigned want);
    send_request(MODE_QUERY, $urandom_range(0, 255), 1'($urandom_range(0, 1)), want);
  endtask

  // Drain, then change the scan span while the block is idle.
  task automatic set_span(input int unsigned n);
    stop_requests();
    while (expected_runs.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= n[CNT_W-1:0];
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    span_shadow = (n > MAP_ENTRIES) ? MAP_ENTRIES : n;
  endtask

  // result checker and receiver stall generator
  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (expected_runs.size() == 0) begin
        $display("%0t: unexpected result start=%0d end=%0d len=%0d", $time,
                 res_if.run_start, res_if.run_end, res_if.run_length);
        failed = 1;
      end else begin
        run_rec_t e;
        e = expected_runs.pop_front();
        if (e.run_start !== res_if.run_start || e.run_end !== res_if.run_end ||
            e.run_length !== res_if.run_length ||
            e.present_count !== res_if.present_count ||
            e.no_gaps !== res_if.no_gaps || e.last_result !== res_if.last_result) begin
          $display("%0t: mismatch exp s=%0d e=%0d l=%0d p=%0d ng=%0b last=%0b",
                   $time, e.run_start, e.run_end, e.run_length, e.present_count,
                   e.no_gaps, e.last_result);
          $display("%0t:          got s=%0d e=%0d l=%0d p=%0d ng=%0b last=%0b",
                   $time, res_if.run_start, res_if.run_end, res_if.run_length,
                   res_if.present_count, res_if.no_gaps, res_if.last_result);
          failed = 1;
        end
      end
    end
  end

  int unsigned stall_left;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stall_left    <= 0;
      res_if.ready  <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left   <= stall_left - 1;
      res_if.ready <= (stall_left == 1);
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left   <= $urandom_range(1, 9);
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= 1'b1;
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // directed: empty map, single present entries, ends, range_count corners
  task automatic test_directed;
    query_runs(0);                      // everything missing, count 0 -> 1
    query_runs(127);                    // count beyond the cap
    for (int i = 0; i < 256; i += 2) map_shadow[i] = map_shadow[i];
    write_entry(0, 1'b1);
    write_entry(255, 1'b1);
    write_entry(128, 1'b1);
    write_entry(64, 1'b1);
    query_runs(64);
    query_runs(1);
    write_entry(64, 1'b0);              // clear again
    query_runs(3);
  endtask

  // fill the map, so no gaps, then a single hole at either end
  task automatic test_no_gaps;
    for (int i = 0; i < 256; i++) write_entry(i, 1'b1);
    query_runs(5);
    write_entry(255, 1'b0);
    query_runs(2);                      // gap running to the end
    write_entry(255, 1'b1);
    write_entry(0, 1'b0);
    query_runs(64);
    write_entry(0, 1'b1);
  endtask

  // span changes, extremes included; entries past the span are stored only
  task automatic test_span;
    set_span(1);
    query_runs(4);
    write_entry(0, 1'b0);
    query_runs(4);
    set_span(0);
    query_runs(4);                      // nothing scanned
    set_span(511);                      // saturates
    query_runs(10);
    set_span(200);
    write_entry(230, 1'b0);             // outside the span
    query_runs(10);
  endtask

  // random: bursts of random writes, each followed by a query
  task automatic test_random(input int unsigned items);
    int unsigned sent;
    sent = 0;
    while (sent < items) begin
      if ($urandom_range(0, 9) == 0) set_span($urandom_range(1, 256));
      repeat ($urandom_range(1, 12)) begin
        write_entry($urandom_range(0, 255), $urandom_range(0, 3) != 0);
        sent++;
      end
      query_runs($urandom_range(0, 9) == 0 ? $urandom_range(65, 127)
                                            : $urandom_range(0, 64));
      sent++;
    end
  endtask

  initial begin
    failed      = 0;
    idle_on     = 1;
    span_shadow = MAP_ENTRIES;
    foreach (map_shadow[i]) map_shadow[i] = 1'b0;
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_wdata_i        = '0;
    req_if.valid       = 1'b0;
    req_if.mode        = MODE_WRITE;
    req_if.entry_index = '0;
    req_if.entry_value = 1'b0;
    req_if.range_count = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_no_gaps();
    test_span();
    set_span(256);
    test_random(65);
    idle_on = 0;
    test_random(25);
    stop_requests();

    while (expected_runs.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (!failed) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
